FILE: src/lru_pr_pkg.sv
// Shared constants and controller-to-datapath command type for the LRU page replacement unit.
package lru_pr_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 16;
   localparam int FRAME_BITS = $clog2(MAX_FRAMES);
   localparam int RANK_BITS  = FRAME_BITS;
   localparam int CFG_BITS   = 5;
   localparam int COUNT_BITS = 32;
   localparam int TREE_SIZE  = 1 << FRAME_BITS;

   localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(MAX_FRAMES);

   typedef struct packed {
      logic load;     // latch request beat
      logic compare;  // register match / empty / victim vectors
      logic commit;   // update frame state and load result register
   } dp_cmd_type;

endpackage

FILE: src/lru_pr_ctrl.sv
// Sequencer for the LRU page replacement unit: handshakes and datapath commands.
module lru_pr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lru_pr_pkg::dp_cmd_type cmd
);
   import lru_pr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, commit, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_UPDATE) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || commit);
   assign accept    = req_valid && !req_stall;

   assign cmd.load    = accept;
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.commit  = commit;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = accept ? ST_COMPARE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/lru_pr_datapath.sv
// Frame table, lookup, LRU victim tree, rank update and result register.
module lru_pr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lru_pr_pkg::dp_cmd_type            cmd,
   input  logic                              csr_write,
   input  logic [lru_pr_pkg::CFG_BITS-1:0]   csr_frames_in_use,
   input  logic [lru_pr_pkg::PAGE_BITS-1:0]  req_page,
   input  logic                              req_is_last,
   output logic                              rsp_hit,
   output logic [lru_pr_pkg::FRAME_BITS-1:0] rsp_frame_index,
   output logic                              rsp_evicted,
   output logic [lru_pr_pkg::PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [lru_pr_pkg::COUNT_BITS-1:0] rsp_fault_total,
   output logic                              rsp_done_res
);
   import lru_pr_pkg::*;

   // configuration and frame state
   logic [CFG_BITS-1:0]   frames_ff;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
   logic [RANK_BITS-1:0]  rank_ff  [MAX_FRAMES];
   logic [RANK_BITS-1:0]  rank_in  [MAX_FRAMES];
   logic [COUNT_BITS-1:0] fault_ff, fault_in;

   // request beat
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  last_ff;

   // lookup stage
   logic [MAX_FRAMES-1:0] match_ff, match_in;
   logic [MAX_FRAMES-1:0] empty_ff, empty_in;
   logic [FRAME_BITS-1:0] victim_ff, victim_in;
   logic [FRAME_BITS:0]   count_ff, count_in;
   logic [CFG_BITS-1:0]   n_eff;

   // victim tree
   logic                  key_use [FRAME_BITS+1][TREE_SIZE];
   logic [RANK_BITS-1:0]  key_rank[FRAME_BITS+1][TREE_SIZE];
   logic [FRAME_BITS-1:0] key_idx [FRAME_BITS+1][TREE_SIZE];

   // update stage
   logic                  any_hit, any_empty;
   logic [FRAME_BITS-1:0] hit_idx, empty_idx, sel;
   logic [RANK_BITS-1:0]  old_age;
   logic                  right_wins;

   always_comb begin
      if (frames_ff == '0) begin
         n_eff = CFG_BITS'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         n_eff = CFG_BITS'(MAX_FRAMES);
      end else begin
         n_eff = frames_ff;
      end
   end

   // lookup: parallel tag compare, empty scan, occupancy count
   always_comb begin
      count_in = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match_in[i] = valid_ff[i] && (page_mem[i] == page_ff) && (32'(i) < 32'(n_eff));
         empty_in[i] = !valid_ff[i] && (32'(i) < 32'(n_eff));
         count_in    = count_in + (FRAME_BITS+1)'(valid_ff[i]);
      end
   end

   // oldest frame in use; ties go to the lower index
   always_comb begin
      right_wins = 1'b0;
      for (int i = 0; i < TREE_SIZE; i++) begin
         if (i < MAX_FRAMES) begin
            key_use[0][i]  = (32'(i) < 32'(n_eff));
            key_rank[0][i] = rank_ff[i % MAX_FRAMES];
         end else begin
            key_use[0][i]  = 1'b0;
            key_rank[0][i] = '0;
         end
         key_idx[0][i] = FRAME_BITS'(i);
      end
      for (int lv = 1; lv <= FRAME_BITS; lv++) begin
         for (int j = 0; j < TREE_SIZE; j++) begin
            key_use[lv][j]  = 1'b0;
            key_rank[lv][j] = '0;
            key_idx[lv][j]  = '0;
            if (j < (TREE_SIZE >> lv)) begin
               right_wins = ({key_use[lv-1][2*j+1], key_rank[lv-1][2*j+1]} >
                             {key_use[lv-1][2*j],   key_rank[lv-1][2*j]});
               if (right_wins) begin
                  key_use[lv][j]  = key_use[lv-1][2*j+1];
                  key_rank[lv][j] = key_rank[lv-1][2*j+1];
                  key_idx[lv][j]  = key_idx[lv-1][2*j+1];
               end else begin
                  key_use[lv][j]  = key_use[lv-1][2*j];
                  key_rank[lv][j] = key_rank[lv-1][2*j];
                  key_idx[lv][j]  = key_idx[lv-1][2*j];
               end
            end
         end
      end
      victim_in = key_idx[FRAME_BITS][0];
   end

   // update: pick the frame, age the younger ones
   always_comb begin
      any_hit   = |match_ff;
      any_empty = |empty_ff;
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = FRAME_BITS'(i);
         if (empty_ff[i]) empty_idx = FRAME_BITS'(i);
      end
      if (any_hit) begin
         sel     = hit_idx;
         old_age = rank_ff[hit_idx];
      end else if (any_empty) begin
         sel     = empty_idx;
         old_age = RANK_BITS'(count_ff);
      end else begin
         sel     = victim_ff;
         old_age = rank_ff[victim_ff];
      end
      valid_in      = valid_ff;
      valid_in[sel] = 1'b1;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (32'(i) == 32'(sel)) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && (rank_ff[i] < old_age)) begin
            rank_in[i] = rank_ff[i] + RANK_BITS'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
      if (!any_hit && (fault_ff != '1)) begin
         fault_in = fault_ff + COUNT_BITS'(1);
      end else begin
         fault_in = fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
         valid_ff  <= '0;
         fault_ff  <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_write) frames_ff <= csr_frames_in_use;
         if (cmd.commit) begin
            valid_ff <= valid_in;
            fault_ff <= fault_in;
            for (int i = 0; i < MAX_FRAMES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_page;
         last_ff <= req_is_last;
      end
      if (cmd.compare) begin
         match_ff  <= match_in;
         empty_ff  <= empty_in;
         victim_ff <= victim_in;
         count_ff  <= count_in;
      end
      if (cmd.commit) begin
         if (!any_hit) page_mem[sel] <= page_ff;
         rsp_hit          <= any_hit;
         rsp_frame_index  <= sel;
         rsp_evicted      <= !any_hit && !any_empty;
         rsp_evicted_page <= (!any_hit && !any_empty) ? page_mem[victim_ff] : '0;
         rsp_fault_total  <= fault_in;
         rsp_done_res     <= last_ff;
      end
   end

endmodule

FILE: src/lru_page_replacement.sv
// LRU page replacement unit: an accepted reference beat goes through a lookup state (tag compare,
// victim tree), then an update state that loads the result register; the next beat is taken in
// the update state if the result register is free.
// A stalled result holds the block in the update cycle.
// Synchronous reset empties all frames, clears ranks and the fault count, and sets 16 frames.
// Configuration writes are taken in any cycle (csr_ready stays high).
module lru_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lru_pr_pkg::CFG_BITS-1:0]   csr_frames_in_use,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lru_pr_pkg::PAGE_BITS-1:0]  req_page,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [lru_pr_pkg::FRAME_BITS-1:0] rsp_frame_index,
   output logic                              rsp_evicted,
   output logic [lru_pr_pkg::PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [lru_pr_pkg::COUNT_BITS-1:0] rsp_fault_total,
   output logic                              rsp_done_res
);
   import lru_pr_pkg::*;

   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   lru_pr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lru_pr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write         (csr_valid),
      .csr_frames_in_use (csr_frames_in_use),
      .req_page          (req_page),
      .req_is_last       (req_is_last),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .rsp_done_res      (rsp_done_res)
   );

endmodule
